// ===== rtl/hdlc_fd_pkg.sv =====
// shared types, constants and crc function for the hdlc frame decoder
`timescale 1ns / 1ps

package hdlc_fd_pkg;

  localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
  localparam logic [7:0]  ESC_BYTE   = 8'h7D;
  localparam logic [7:0]  ESC_MASK   = 8'h20;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

  // entries in the queue between front and back
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);

  // result kinds on the output channel
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_EOF     = 1'b1;

  // operation classes handed from front to back
  typedef enum logic {
    OP_DATA = 1'b0,
    OP_FLAG = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
  } op_t;

  // bytewise crc-16/x.25 update, reflected
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/hdlc_fd_if.sv =====
// valid/ready channel interfaces for the hdlc frame decoder
`timescale 1ns / 1ps

interface hdlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface hdlc_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       frame_good;

  modport source (output valid, output out_kind, output out_byte, output frame_good,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input frame_good,
                  output ready);
endinterface

// ===== rtl/hdlc_fd_queue.sv =====
// two-entry operation queue between front and back
`timescale 1ns / 1ps

module hdlc_fd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hdlc_fd_pkg::op_t   push_op,
  output logic               full,
  input  logic               pop,
  output hdlc_fd_pkg::op_t   pop_op,
  output logic               empty
);
  import hdlc_fd_pkg::*;

  op_t                 entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCOUNT_W-1:0] count_r, count_nxt;
  logic                do_push;
  logic                do_pop;

  assign full    = (count_r == QCOUNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_op  = entry_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ===== rtl/hdlc_fd_front.sv =====
// front end: accepts link bytes, strips escapes and classifies flags
`timescale 1ns / 1ps

module hdlc_fd_front (
  input  logic             clk,
  input  logic             rst_n,
  hdlc_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             q_push,
  output hdlc_fd_pkg::op_t q_op
);
  import hdlc_fd_pkg::*;

  logic esc_r, esc_nxt;
  logic beat;
  logic is_flag;
  logic is_esc;

  assign in_ch.ready = !q_full;
  assign beat        = in_ch.valid && in_ch.ready;
  assign is_flag     = (in_ch.in_byte == FLAG_BYTE);
  assign is_esc      = (in_ch.in_byte == ESC_BYTE);

  // classify and unescape
  always_comb begin
    esc_nxt   = esc_r;
    q_push    = 1'b0;
    q_op.kind = OP_DATA;
    q_op.data = esc_r ? (in_ch.in_byte ^ ESC_MASK) : in_ch.in_byte;
    if (beat) begin
      if (is_flag) begin
        q_push    = 1'b1;
        q_op.kind = OP_FLAG;
        esc_nxt   = 1'b0;
      end else if (is_esc) begin
        esc_nxt = 1'b1;
      end else begin
        q_push  = 1'b1;
        esc_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
    end else begin
      esc_r <= esc_nxt;
    end
  end

endmodule

// ===== rtl/hdlc_fd_back.sv =====
// back end: fcs delay line, running crc and registered result output
`timescale 1ns / 1ps

module hdlc_fd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  hdlc_fd_pkg::op_t q_op,
  output logic             q_pop,
  hdlc_out_if.source       out_ch
);
  import hdlc_fd_pkg::*;

  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_good_r, out_good_nxt;
  logic        slot_free;
  logic        emit;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign q_pop     = !q_empty && slot_free;

  // execute one queued operation
  always_comb begin
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    count_nxt    = count_r;
    crc_nxt      = crc_r;
    emit         = 1'b0;
    out_kind_nxt = out_kind_r;
    out_byte_nxt = out_byte_r;
    out_good_nxt = out_good_r;
    if (q_pop) begin
      unique case (q_op.kind)
        OP_FLAG: begin
          if (count_r == 2'd3) begin
            emit         = 1'b1;
            out_kind_nxt = KIND_EOF;
            out_byte_nxt = 8'h00;
            out_good_nxt = ((crc_r ^ CRC_XOROUT) == {held1_r, held0_r});
          end
          held0_nxt = 8'h00;
          held1_nxt = 8'h00;
          count_nxt = 2'd0;
          crc_nxt   = CRC_INIT;
        end
        OP_DATA: begin
          if (count_r >= 2'd2) begin
            emit         = 1'b1;
            out_kind_nxt = KIND_PAYLOAD;
            out_byte_nxt = held0_r;
            out_good_nxt = 1'b0;
            crc_nxt      = crc_update(crc_r, held0_r);
            held0_nxt    = held1_r;
            held1_nxt    = q_op.data;
            count_nxt    = 2'd3;
          end else begin
            if (count_r[0]) begin
              held1_nxt = q_op.data;
            end else begin
              held0_nxt = q_op.data;
            end
            count_nxt = count_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // output slot holds a result until taken
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held0_r     <= 8'h00;
      held1_r     <= 8'h00;
      count_r     <= 2'd0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      held0_r     <= held0_nxt;
      held1_r     <= held1_nxt;
      count_r     <= count_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= out_kind_nxt;
      out_byte_r <= out_byte_nxt;
      out_good_r <= out_good_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_kind   = out_kind_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.frame_good = out_good_r;

endmodule

// ===== rtl/hdlc_frame_decoder_core.sv =====
// path: an accepted byte is written into the queue and any result is registered
// in the output slot; a payload byte leaves once two more data bytes arrive
// throughput: one link byte per cycle; the byte-wide crc update in the back end
// sets the cycle, and a two-entry queue lets front and back stall apart
// reset (rst_n low, synchronous): escape, delay line, count, queue and
// output slot clear and the crc returns to 0xffff
`timescale 1ns / 1ps

module hdlc_frame_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  hdlc_in_if.sink     in_ch,
  hdlc_out_if.source  out_ch
);
  import hdlc_fd_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  op_t  push_op;
  op_t  pop_op;

  // unescape and classify
  hdlc_fd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_op   (push_op)
  );

  // decoupling queue
  hdlc_fd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (pop_op),
    .empty   (q_empty)
  );

  // delay line, crc and output
  hdlc_fd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_op    (pop_op),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
